/* hw/rtl/heart_path_conduction_automaton_defines.svh */
// Assertion macros shared by the conduction path automaton RTL.
`ifndef HEART_PATH_CONDUCTION_AUTOMATON_DEFINES_SVH
`define HEART_PATH_CONDUCTION_AUTOMATON_DEFINES_SVH
`ifndef SYNTHESIS
`define HPCA_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("hpca assertion failed");
`define HPCA_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("hpca assertion failed");
`else
`define HPCA_ASSERT_IMPLY(label, clk, rst_n, pre, post)
`define HPCA_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

/* hw/rtl/hpca_pkg.sv */
// Types and constants of the conduction path automaton.
`default_nettype none
package hpca_pkg;

	typedef enum logic [2:0] {
		M_IDLE = 3'd0,
		M_FWD  = 3'd1,
		M_BWD  = 3'd2,
		M_REFR = 3'd3,
		M_CONF = 3'd4
	} hpca_mode_t;

	typedef enum logic [1:0] {
		ST_READY,
		ST_TEST,
		ST_HOLD
	} hpca_core_st_t;

	typedef enum logic [2:0] {
		CL_IDLE,
		CL_MUL_P,
		CL_MUL_A,
		CL_MUL_B,
		CL_ABS,
		CL_MUL_M,
		CL_TEN,
		CL_CMP
	} hpca_coll_st_t;

	localparam logic CFG_FORWARD_RELOAD  = 1'b0;
	localparam logic CFG_BACKWARD_RELOAD = 1'b1;

	localparam int RELOAD_RESET = 100;

	typedef struct packed {
		logic first_node_active;
		logic second_node_active;
	} hpca_in_t;

	typedef struct packed {
		logic       fire_first_node;
		logic       fire_second_node;
		logic [2:0] path_mode;
	} hpca_out_t;

	typedef struct packed {
		logic done;
		logic annihilate;
	} hpca_coll_sts_t;

endpackage
`default_nettype wire

/* hw/rtl/heart_path_conduction_automaton.sv */
// The result is registered; in the conflict mode with both timers running, the
// serial collision test runs first and the result is registered when it is done.
// Throughput: one request per cycle while the output is not stalled; a conflict
// test holds off the next request until its shift-add sequence over the timer bits ends.
// Reset: asynchronous; mode idle, reloads and timers 100, result register empty.
`default_nettype none
module heart_path_conduction_automaton
	import hpca_pkg::*;
#(
	parameter int TIMER_WIDTH = 12
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire hpca_in_t               in_data,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output hpca_out_t                   out_data,
	input  wire logic                   cfg_we,
	input  wire logic                   cfg_index,
	input  wire logic [TIMER_WIDTH-1:0] cfg_data
);

	logic [TIMER_WIDTH-1:0] fwd_reload_q;
	logic [TIMER_WIDTH-1:0] bwd_reload_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_reload_q <= TIMER_WIDTH'(RELOAD_RESET);
			bwd_reload_q <= TIMER_WIDTH'(RELOAD_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FORWARD_RELOAD:  fwd_reload_q <= cfg_data;
				CFG_BACKWARD_RELOAD: bwd_reload_q <= cfg_data;
				default:             fwd_reload_q <= fwd_reload_q;
			endcase
		end
	end

	hpca_core #(
		.TIMER_WIDTH(TIMER_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.fwd_reload(fwd_reload_q),
		.bwd_reload(bwd_reload_q)
	);

endmodule
`default_nettype wire

/* hw/rtl/hpca_collide.sv */
// Bit-serial collision test: |Df*Db - cf*Db - cb*Df| * 10 * min(Df,Db) < 9*Df*Db.
`default_nettype none
`include "heart_path_conduction_automaton_defines.svh"
module hpca_collide
	import hpca_pkg::*;
#(
	parameter int TIMER_WIDTH = 12
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [TIMER_WIDTH-1:0] fwd_reload,
	input  wire logic [TIMER_WIDTH-1:0] bwd_reload,
	input  wire logic [TIMER_WIDTH-1:0] fwd_count,
	input  wire logic [TIMER_WIDTH-1:0] bwd_count,
	output hpca_coll_sts_t              sts
);

	localparam int AW = 3 * TIMER_WIDTH + 6;
	localparam int PW = 2 * TIMER_WIDTH;
	localparam int RW = 2 * TIMER_WIDTH + 4;
	localparam int CW = $clog2(TIMER_WIDTH);
	localparam logic [CW-1:0] LAST = CW'(TIMER_WIDTH - 1);

	hpca_coll_st_t st_q, st_d;
	logic                   done_q;
	logic [AW-1:0]          acc_q;
	logic [AW-1:0]          mcand_q;
	logic [TIMER_WIDTH-1:0] mplier_q;
	logic [CW-1:0]          cnt_q;
	logic [PW-1:0]          p_q;
	logic [RW-1:0]          rhs_q;
	logic                   ann_q;

	logic                   last;
	logic [TIMER_WIDTH-1:0] min_rl;
	logic [AW-1:0]          acc_add;
	logic [AW-1:0]          acc_sub;
	logic [AW-1:0]          acc_abs;

	assign last    = (cnt_q == LAST);
	assign min_rl  = (fwd_reload < bwd_reload) ? fwd_reload : bwd_reload;
	assign acc_add = mplier_q[0] ? (acc_q + mcand_q) : acc_q;
	assign acc_sub = mplier_q[0] ? (acc_q - mcand_q) : acc_q;
	assign acc_abs = acc_q[AW-1] ? (AW'(0) - acc_q) : acc_q;

	always_comb begin
		st_d = st_q;
		case (st_q)
			CL_IDLE:  if (start) st_d = (min_rl == '0) ? CL_IDLE : CL_MUL_P;
			CL_MUL_P: if (last) st_d = CL_MUL_A;
			CL_MUL_A: if (last) st_d = CL_MUL_B;
			CL_MUL_B: if (last) st_d = CL_ABS;
			CL_ABS:   st_d = CL_MUL_M;
			CL_MUL_M: if (last) st_d = CL_TEN;
			CL_TEN:   st_d = CL_CMP;
			CL_CMP:   st_d = CL_IDLE;
			default:  st_d = CL_IDLE;
		endcase
	end

	always_comb begin
		sts.done       = done_q;
		sts.annihilate = ann_q;
	end

	// The result is ready in the cycle after the compare, or straight after start
	// when the smaller reload is zero and the threshold is unbounded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= CL_IDLE;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			done_q <= (st_q == CL_CMP) || (st_q == CL_IDLE && start && min_rl == '0);
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			CL_IDLE: begin
				if (start) begin
					acc_q    <= '0;
					mcand_q  <= AW'(bwd_reload);
					mplier_q <= fwd_reload;
					cnt_q    <= '0;
					ann_q    <= 1'b1;
				end
			end
			CL_MUL_P: begin
				acc_q <= acc_add;
				if (last) begin
					p_q      <= acc_add[PW-1:0];
					mcand_q  <= AW'(bwd_reload);
					mplier_q <= fwd_count;
					cnt_q    <= '0;
				end else begin
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					cnt_q    <= cnt_q + CW'(1);
				end
			end
			CL_MUL_A: begin
				acc_q <= acc_sub;
				if (last) begin
					mcand_q  <= AW'(fwd_reload);
					mplier_q <= bwd_count;
					cnt_q    <= '0;
				end else begin
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					cnt_q    <= cnt_q + CW'(1);
				end
			end
			CL_MUL_B: begin
				acc_q    <= acc_sub;
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
				cnt_q    <= cnt_q + CW'(1);
			end
			CL_ABS: begin
				mcand_q  <= acc_abs;
				acc_q    <= '0;
				mplier_q <= min_rl;
				cnt_q    <= '0;
				rhs_q    <= RW'({p_q, 3'b000}) + RW'(p_q);
			end
			CL_MUL_M: begin
				acc_q    <= acc_add;
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
				cnt_q    <= cnt_q + CW'(1);
			end
			CL_TEN: begin
				acc_q <= (acc_q << 3) + (acc_q << 1);
			end
			CL_CMP: begin
				ann_q <= (acc_q < AW'(rhs_q));
			end
			default: begin
				ann_q <= 1'b1;
			end
		endcase
	end

	`HPCA_ASSERT_NEXT(a_done_pulse, clk, arst_n, done_q, !done_q)
	`HPCA_ASSERT_IMPLY(a_done_source, clk, arst_n, done_q, $past(st_q) == CL_CMP || $past(st_q) == CL_IDLE)
	`HPCA_ASSERT_IMPLY(a_mag_positive, clk, arst_n, st_q == CL_MUL_M, !acc_q[AW-1])

endmodule
`default_nettype wire

/* hw/rtl/hpca_core.sv */
// Path mode and timer state, request handshake and result register.
`default_nettype none
`include "heart_path_conduction_automaton_defines.svh"
module hpca_core
	import hpca_pkg::*;
#(
	parameter int TIMER_WIDTH = 12
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire hpca_in_t               in_data,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output hpca_out_t                   out_data,
	input  wire logic [TIMER_WIDTH-1:0] fwd_reload,
	input  wire logic [TIMER_WIDTH-1:0] bwd_reload
);

	hpca_core_st_t st_q, st_d;
	hpca_mode_t    mode_q, mode_d;
	logic [TIMER_WIDTH-1:0] fcnt_q, fcnt_d;
	logic [TIMER_WIDTH-1:0] bcnt_q, bcnt_d;
	logic                   out_valid_q;
	hpca_out_t              out_q;
	hpca_out_t              hold_q;
	hpca_out_t              res;
	hpca_coll_sts_t         sts;

	logic accept, needs_test, out_free, commit, load_out, coll_start;

	hpca_collide #(
		.TIMER_WIDTH(TIMER_WIDTH)
	) u_collide (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (coll_start),
		.fwd_reload(fwd_reload),
		.bwd_reload(bwd_reload),
		.fwd_count (fcnt_q),
		.bwd_count (bcnt_q),
		.sts       (sts)
	);

	assign accept     = in_valid && !in_stall;
	assign needs_test = (mode_q == M_CONF) && (fcnt_q != '0) && (bcnt_q != '0);
	assign out_free   = !out_valid_q || !out_stall;

	// One tick of the path automaton; the collision outcome is only used in
	// the conflict mode with both timers still running.
	always_comb begin
		mode_d = mode_q;
		fcnt_d = fcnt_q;
		bcnt_d = bcnt_q;
		res    = '0;
		case (mode_q)
			M_IDLE: begin
				if (in_data.first_node_active) mode_d = M_FWD;
				else if (in_data.second_node_active) mode_d = M_BWD;
			end
			M_FWD: begin
				if (in_data.second_node_active) begin
					mode_d = M_CONF;
				end else if (fcnt_q == '0) begin
					fcnt_d               = fwd_reload;
					res.fire_second_node = 1'b1;
					mode_d               = M_REFR;
				end else begin
					fcnt_d = fcnt_q - TIMER_WIDTH'(1);
				end
			end
			M_BWD: begin
				if (in_data.first_node_active) begin
					mode_d = M_CONF;
				end else if (bcnt_q == '0) begin
					bcnt_d              = bwd_reload;
					res.fire_first_node = 1'b1;
					mode_d              = M_REFR;
				end else begin
					bcnt_d = bcnt_q - TIMER_WIDTH'(1);
				end
			end
			M_REFR: mode_d = M_IDLE;
			M_CONF: begin
				if (bcnt_q == '0) begin
					bcnt_d              = bwd_reload;
					res.fire_first_node = 1'b1;
					mode_d              = M_REFR;
				end else if (fcnt_q == '0) begin
					fcnt_d               = fwd_reload;
					res.fire_second_node = 1'b1;
					mode_d               = M_REFR;
				end else if (sts.annihilate) begin
					fcnt_d = fwd_reload;
					bcnt_d = bwd_reload;
					mode_d = M_REFR;
				end else begin
					fcnt_d = fcnt_q - TIMER_WIDTH'(1);
					bcnt_d = bcnt_q - TIMER_WIDTH'(1);
				end
			end
			default: mode_d = M_IDLE;
		endcase
		res.path_mode = mode_d;
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_READY: begin
				if (accept && needs_test) st_d = ST_TEST;
				else if (accept && !out_free) st_d = ST_HOLD;
			end
			ST_TEST:  if (sts.done) st_d = out_free ? ST_READY : ST_HOLD;
			ST_HOLD:  if (out_free) st_d = ST_READY;
			default:  st_d = ST_READY;
		endcase
	end

	always_comb begin
		in_stall   = (st_q != ST_READY);
		coll_start = 1'b0;
		commit     = 1'b0;
		load_out   = 1'b0;
		case (st_q)
			ST_READY: begin
				coll_start = accept && needs_test;
				commit     = accept && !needs_test;
				load_out   = commit && out_free;
			end
			ST_TEST: begin
				commit   = sts.done;
				load_out = commit && out_free;
			end
			ST_HOLD:  load_out = out_free;
			default: begin
				commit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_READY;
			mode_q      <= M_IDLE;
			fcnt_q      <= TIMER_WIDTH'(RELOAD_RESET);
			bcnt_q      <= TIMER_WIDTH'(RELOAD_RESET);
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (commit) begin
				mode_q <= mode_d;
				fcnt_q <= fcnt_d;
				bcnt_q <= bcnt_d;
			end
			if (load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit && !out_free) hold_q <= res;
		if (load_out) out_q <= (st_q == ST_HOLD) ? hold_q : res;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`HPCA_ASSERT_IMPLY(a_test_in_conflict, clk, arst_n, st_q == ST_TEST, mode_q == M_CONF)
	`HPCA_ASSERT_IMPLY(a_done_when_waiting, clk, arst_n, sts.done, st_q == ST_TEST)
	`HPCA_ASSERT_IMPLY(a_hold_has_output, clk, arst_n, st_q == ST_HOLD, out_valid_q)

endmodule
`default_nettype wire
